>>> rtl/core/lkv_pkg.sv
// Package for the LRU key-value cache: payload types, response constants
// and the command struct from the controller to the datapath.
// No dependencies.
package lkv_pkg;

   typedef logic signed [31:0] key_type;
   typedef logic signed [31:0] value_type;
   typedef logic [4:0]         capacity_type;

   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   localparam capacity_type CAPACITY_RESET = 5'd16;
   localparam value_type    MISS_VALUE     = 32'shFFFF_FFFF;
   localparam value_type    PUT_VALUE      = 32'sh0000_0000;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic update;
      logic load_rsp;
   } cmd_type;

endpackage

>>> rtl/core/lkv_req_if.sv
// Request channel of the LRU key-value cache: valid/ready and payload.
// Depends on lkv_pkg.
interface lkv_req_if;
   logic                 valid;
   logic                 ready;
   logic                 action;
   lkv_pkg::key_type     key;
   lkv_pkg::value_type   value;

   modport source (output valid, action, key, value, input ready);
   modport sink   (input valid, action, key, value, output ready);
endinterface

>>> rtl/core/lkv_rsp_if.sv
// Response channel of the LRU key-value cache: valid/ready and payload.
// Depends on lkv_pkg.
interface lkv_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 hit;
   lkv_pkg::value_type   read_value;
   logic                 evicted;

   modport source (output valid, hit, read_value, evicted, input ready);
   modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

>>> rtl/core/lkv_ctrl.sv
// Sequencer of the LRU key-value cache: steps each request through
// capture, lookup, update and response load. Depends on lkv_pkg.
module lkv_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output lkv_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      load;

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;
      load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

      cmd.capture  = accept;
      cmd.lookup   = (state_ff == ST_LOOKUP);
      cmd.update   = (state_ff == ST_UPDATE);
      cmd.load_rsp = load;

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DONE;
         ST_DONE: begin
            if (load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // A waiting result leaves only when taken; a new one may replace it
      // in the same cycle.
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/lkv_datapath.sv
// Datapath of the LRU key-value cache: key lanes with valid bits and
// recency ranks, value memory, capacity register and response register.
// Depends on lkv_pkg; driven by commands from lkv_ctrl.
module lkv_datapath #(
   parameter  int ENTRIES = 16,
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int CW = $clog2(ENTRIES + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lkv_pkg::cmd_type     cmd,
   input  logic                 req_action,
   input  lkv_pkg::key_type     req_key,
   input  lkv_pkg::value_type   req_value,
   input  logic                 csr_wr_en,
   input  lkv_pkg::capacity_type csr_wr_data,
   output logic                 rsp_hit,
   output lkv_pkg::value_type   rsp_read_value,
   output logic                 rsp_evicted,
   output logic [CW-1:0]        occ_count,
   output logic [ENTRIES-1:0]   valid_vec
);

   localparam int EW = (CW > 5) ? CW : 5;

   lkv_pkg::capacity_type capacity_ff, capacity_in;

   lkv_pkg::key_type   key_ff  [ENTRIES];
   lkv_pkg::key_type   key_in  [ENTRIES];
   logic [IW-1:0]      rank_ff [ENTRIES];
   logic [IW-1:0]      rank_in [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]      count_ff, count_in;

   logic               op_put_ff, op_put_in;
   lkv_pkg::key_type   op_key_ff, op_key_in;
   lkv_pkg::value_type op_value_ff, op_value_in;

   logic               hit_ff, hit_in;
   logic [IW-1:0]      hit_idx_ff, hit_idx_in;
   logic [IW-1:0]      hit_rank_ff, hit_rank_in;
   logic               evict_ff, evict_in;
   logic [IW-1:0]      slot_ff, slot_in;

   lkv_pkg::value_type value_mem [ENTRIES];
   lkv_pkg::value_type rdata_ff;
   logic               mem_we;
   logic [IW-1:0]      mem_waddr;

   logic               rsp_hit_ff, rsp_hit_in;
   lkv_pkg::value_type rsp_value_ff, rsp_value_in;
   logic               rsp_evicted_ff, rsp_evicted_in;

   logic [ENTRIES-1:0] match_vec;
   logic [IW-1:0]      victim_idx;
   logic [IW-1:0]      free_idx;
   logic [IW-1:0]      last_rank;
   logic [EW-1:0]      eff_cap;
   logic               full;

   // Lookup: compare every lane against the captured key. The valid ranks
   // always form 0 .. count-1, so the least recent entry is the one whose
   // rank equals count-1.
   always_comb begin
      last_rank   = IW'(count_ff - CW'(1));
      hit_idx_in  = '0;
      victim_idx  = '0;
      free_idx    = '0;
      hit_rank_in = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         match_vec[i] = valid_ff[i] && (key_ff[i] == op_key_ff);
         if (match_vec[i]) hit_idx_in = IW'(i);
         if (valid_ff[i] && (rank_ff[i] == last_rank)) victim_idx = IW'(i);
         if (!valid_ff[i]) free_idx = IW'(i);
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_vec[i]) hit_rank_in = hit_rank_in | rank_ff[i];
      end

      if (capacity_ff == '0) begin
         eff_cap = EW'(1);
      end else begin
         eff_cap = EW'(capacity_ff);
      end
      if (eff_cap > EW'(ENTRIES)) eff_cap = EW'(ENTRIES);
      full = (EW'(count_ff) >= eff_cap);

      hit_in   = |match_vec;
      evict_in = op_put_ff && !hit_in && full;
      slot_in  = evict_in ? victim_idx : free_idx;
   end

   // Update: reorder ranks, insert or overwrite, and write the value memory.
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i]  = key_ff[i];
         rank_in[i] = rank_ff[i];
         if (cmd.update) begin
            if (hit_ff) begin
               if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + IW'(1);
               end
               if (IW'(i) == hit_idx_ff) rank_in[i] = '0;
            end else if (op_put_ff) begin
               if (IW'(i) == slot_ff) begin
                  valid_in[i] = 1'b1;
                  rank_in[i]  = '0;
                  key_in[i]   = op_key_ff;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + IW'(1);
               end
            end
         end
      end
      if (cmd.update && !hit_ff && op_put_ff && !evict_ff) begin
         count_in = count_ff + CW'(1);
      end

      mem_we    = cmd.update && op_put_ff;
      mem_waddr = hit_ff ? hit_idx_ff : slot_ff;
   end

   always_comb begin
      capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;

      op_put_in   = op_put_ff;
      op_key_in   = op_key_ff;
      op_value_in = op_value_ff;
      if (cmd.capture) begin
         op_put_in   = (req_action == lkv_pkg::ACTION_PUT);
         op_key_in   = req_key;
         op_value_in = req_value;
      end

      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_evicted_in = rsp_evicted_ff;
      if (cmd.load_rsp) begin
         rsp_hit_in     = hit_ff;
         rsp_evicted_in = evict_ff;
         if (op_put_ff) begin
            rsp_value_in = lkv_pkg::PUT_VALUE;
         end else if (hit_ff) begin
            rsp_value_in = rdata_ff;
         end else begin
            rsp_value_in = lkv_pkg::MISS_VALUE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkv_pkg::CAPACITY_RESET;
         valid_ff    <= '0;
         count_ff    <= '0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
      end else begin
         capacity_ff <= capacity_in;
         valid_ff    <= valid_in;
         count_ff    <= count_in;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= rank_in[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) key_ff[i] <= key_in[i];
      op_put_ff      <= op_put_in;
      op_key_ff      <= op_key_in;
      op_value_ff    <= op_value_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
      if (cmd.lookup) begin
         hit_ff      <= hit_in;
         hit_idx_ff  <= hit_idx_in;
         hit_rank_ff <= hit_rank_in;
         evict_ff    <= evict_in;
         slot_ff     <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) value_mem[mem_waddr] <= op_value_ff;
      if (cmd.update) rdata_ff <= value_mem[hit_idx_ff];
   end

   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign occ_count      = count_ff;
   assign valid_vec      = valid_ff;

endmodule

>>> rtl/core/lru_key_value_cache.sv
// Top level of the LRU key-value cache: controller, datapath and checks.
// Depends on lkv_pkg, lkv_req_if, lkv_rsp_if, lkv_ctrl and lkv_datapath.
//
// Usage:
//   req_if carries one request: action (get or put), key and value. rsp_if
//   returns exactly one response per request: hit, read_value (stored value
//   on a get hit, all ones on a get miss, zero on a put) and evicted.
//   csr_wr_en with csr_wr_data writes the capacity register; write it only
//   while no request is outstanding.
// Timing:
//   An accepted request passes through the lookup, the update of the store
//   with its value-memory read and the response load, which waits in
//   ST_DONE until the output register is free. req_if.ready is high only in
//   the idle state, so no new request is taken before the last one's
//   response is loaded; the accepting idle cycle comes before the lookup.
// Reset:
//   Valid bits, recency ranks and the occupancy count clear in the reset
//   cycle and capacity returns to 16; no clearing pass is needed.
// Stalls:
//   A response waits in the output register while rsp_if.ready is low. The
//   next request is still accepted; its result waits until the register
//   frees up.
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   lkv_req_if.sink               req_if,
   lkv_rsp_if.source             rsp_if,
   input  logic                  csr_wr_en,
   input  lkv_pkg::capacity_type csr_wr_data
);

   localparam int CW = $clog2(ENTRIES + 1);

   lkv_pkg::cmd_type    cmd;
   logic [CW-1:0]       occ_count;
   logic [ENTRIES-1:0]  valid_vec;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .cmd       (cmd)
   );

   lkv_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_action     (req_if.action),
      .req_key        (req_if.key),
      .req_value      (req_if.value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_hit        (rsp_if.hit),
      .rsp_read_value (rsp_if.read_value),
      .rsp_evicted    (rsp_if.evicted),
      .occ_count      (occ_count),
      .valid_vec      (valid_vec)
   );

   // The occupancy count must track the number of valid lanes.
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(occ_count))
      else $error("occupancy count differs from number of valid entries");

   // An eviction only happens on a put of a key that was not stored.
   a_evict_not_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.hit && rsp_if.evicted))
      else $error("response reports both hit and eviction");

   // Once a request is taken the block is busy with it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while previous request in flight");

endmodule
